### src/lage_pkg.sv
package lage_pkg;

   // Configuration register width and reset value
   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] AREA_RESET = 7'd40;

   // Population counter width and its saturation value
   localparam int LIVE_W = 13;
   localparam logic [LIVE_W-1:0] LIVE_MAX = 13'h1FFF;

   // B3/S23 neighbor counts
   localparam int unsigned BIRTH_COUNT   = 3;
   localparam int unsigned SURVIVE_COUNT = 2;

   // Request opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] row;
      logic [5:0] col;
      logic       cell_in;
   } req_data_type;

   typedef struct packed {
      logic              cell_out;
      logic [LIVE_W-1:0] live_count;
   } rsp_data_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     value;
   } csr_data_type;

endpackage

### src/lage_if.sv
interface lage_req_if;
   logic                      valid;
   logic                      ready;
   lage_pkg::req_data_type    data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lage_rsp_if;
   logic                      valid;
   logic                      ready;
   lage_pkg::rsp_data_type    data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lage_csr_if;
   logic                      valid;
   logic                      ready;
   lage_pkg::csr_data_type    data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/lage_row_ram.sv
module lage_row_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### src/lage_cell_rule.sv
module lage_cell_rule #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         row_up,
   input  logic [WIDTH-1:0]         row_mid,
   input  logic [WIDTH-1:0]         row_dn,
   input  logic [$clog2(WIDTH)-1:0] col,
   output logic                     alive
);

   localparam int CAW = $clog2(WIDTH);

   logic           has_left;
   logic           has_right;
   logic [CAW-1:0] col_l;
   logic [CAW-1:0] col_r;
   logic [7:0]     nbrs;
   logic [3:0]     count;

   assign has_left  = (col != '0);
   assign has_right = (int'(col) < WIDTH - 1);
   assign col_l     = col - CAW'(1);
   assign col_r     = col + CAW'(1);

   always_comb begin
      nbrs[0] = has_left  & row_up[col_l];
      nbrs[1] = row_up[col];
      nbrs[2] = has_right & row_up[col_r];
      nbrs[3] = has_left  & row_mid[col_l];
      nbrs[4] = has_right & row_mid[col_r];
      nbrs[5] = has_left  & row_dn[col_l];
      nbrs[6] = row_dn[col];
      nbrs[7] = has_right & row_dn[col_r];
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + 4'(nbrs[i]);
      end
   end

   // born with three, survive with two or three
   assign alive = (count == 4'(lage_pkg::BIRTH_COUNT)) ||
                  (row_mid[col] && (count == 4'(lage_pkg::SURVIVE_COUNT)));

endmodule

### src/life_automaton_grid_engine.sv
// B3/S23 cellular automaton engine over a grid of one-bit cells kept in a
// row-wide synchronous RAM (MAX_ROWS words of MAX_COLS bits). Only the top-left
// rows_in_use by cols_in_use area takes part; cells around it count as dead and
// a step clears every stored cell outside it. Items are taken one at a time:
// a write does a row fetch, then a merged write-back, and gives no result;
// a read fetches its row and then offers its result word, or skips the fetch
// when it falls outside the used area; a step runs row by row over the used
// area through the single rule unit, which evaluates one cell per cycle from
// a three-row window, with one row-wide RAM access per row, and then clears
// the rows below it. After reset a clearing pass writes every row to dead,
// during which req_port.ready stays low (register writes are taken as usual).
// A finished result waits in an output register, so the next item is taken
// while it waits to be collected.
module life_automaton_grid_engine #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   lage_req_if.sink    req_port,
   lage_rsp_if.source  rsp_port,
   lage_csr_if.sink    csr_port
);

   localparam int CFG_W  = lage_pkg::CFG_W;
   localparam int LIVE_W = lage_pkg::LIVE_W;
   localparam int RAW    = $clog2(MAX_ROWS);
   localparam int CAW    = $clog2(MAX_COLS);
   // counters must hold the store size and any register value
   localparam int RCW    = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
   localparam int CCW    = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_CELL_RD = 4'd2;
   localparam logic [3:0] ST_LOAD    = 4'd3;
   localparam logic [3:0] ST_EVAL    = 4'd4;
   localparam logic [3:0] ST_WB      = 4'd5;
   localparam logic [3:0] ST_ZERO    = 4'd6;
   localparam logic [3:0] ST_RESP    = 4'd7;

   // registers
   logic [3:0]              state_ff,     state_in;
   logic [CFG_W-1:0]        rows_ff,      rows_in;
   logic [CFG_W-1:0]        cols_ff,      cols_in;
   logic [RCW-1:0]          row_ff,       row_in;
   logic [CCW-1:0]          col_ff,       col_in;
   logic [MAX_COLS-1:0]     up_ff,        up_in;
   logic [MAX_COLS-1:0]     mid_ff,       mid_in;
   logic [MAX_COLS-1:0]     dn_ff,        dn_in;
   logic [MAX_COLS-1:0]     new_ff,       new_in;
   logic [LIVE_W-1:0]       live_ff,      live_in;
   logic                    res_cell_ff,  res_cell_in;
   logic                    cell_val_ff,  cell_val_in;
   logic                    is_write_ff,  is_write_in;
   logic                    pre_ff,       pre_in;
   logic                    rd_use_ff,    rd_use_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lage_pkg::rsp_data_type  rsp_data_ff,  rsp_data_in;

   // RAM port
   logic                    ram_we;
   logic [RAW-1:0]          ram_waddr;
   logic [MAX_COLS-1:0]     ram_wdata;
   logic [RAW-1:0]          ram_raddr;
   logic [MAX_COLS-1:0]     ram_rdata;

   // decode
   logic [RCW-1:0]          used_rows;
   logic [CCW-1:0]          used_cols;
   logic [MAX_COLS-1:0]     col_mask;
   logic                    req_hit;
   logic                    req_take;
   logic                    born;
   logic [RCW-1:0]          row_p1;
   logic [RCW:0]            row_p2;

   lage_row_ram #(
      .DEPTH (MAX_ROWS),
      .WIDTH (MAX_COLS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lage_cell_rule #(
      .WIDTH (MAX_COLS)
   ) u_cell_rule (
      .row_up  (up_ff),
      .row_mid (mid_ff),
      .row_dn  (dn_ff),
      .col     (CAW'(col_ff)),
      .alive   (born)
   );

   // clamp the used area to the store
   assign used_rows = (RCW'(rows_ff) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_ff);
   assign used_cols = (CCW'(cols_ff) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_ff);

   // columns past the used area read as dead
   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (CCW'(j) < used_cols);
      end
   end

   assign req_hit  = (RCW'(req_port.data.row) < used_rows) &&
                     (CCW'(req_port.data.col) < used_cols);
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take = req_port.valid && req_port.ready;
   assign row_p1   = row_ff + RCW'(1);
   assign row_p2   = (RCW + 1)'(row_ff) + (RCW + 1)'(2);

   assign csr_port.ready = 1'b1;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

   // register writes
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_port.valid) begin
         case (csr_port.data.index)
            lage_pkg::CSR_ROWS: rows_in = csr_port.data.value;
            lage_pkg::CSR_COLS: cols_in = csr_port.data.value;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      dn_in        = dn_ff;
      new_in       = new_ff;
      live_in      = live_ff;
      res_cell_in  = res_cell_ff;
      cell_val_in  = cell_val_ff;
      is_write_in  = is_write_ff;
      pre_in       = pre_ff;
      rd_use_in    = rd_use_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = RAW'(row_ff);
      ram_wdata    = '0;
      ram_raddr    = '0;

      // drop the result word once taken
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;

      case (state_ff)
         ST_CLEAR: begin
            // sweep every row to dead, then open the input
            if (row_ff < RCW'(MAX_ROWS)) begin
               ram_we = 1'b1;
               row_in = row_p1;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               case (req_port.data.opcode)
                  lage_pkg::OP_WRITE: begin
                     // writes outside the used area are dropped
                     if (req_hit) begin
                        ram_raddr   = RAW'(req_port.data.row);
                        row_in      = RCW'(req_port.data.row);
                        col_in      = CCW'(req_port.data.col);
                        cell_val_in = req_port.data.cell_in;
                        is_write_in = 1'b1;
                        state_in    = ST_CELL_RD;
                     end
                  end
                  lage_pkg::OP_READ: begin
                     is_write_in = 1'b0;
                     live_in     = '0;
                     res_cell_in = 1'b0;
                     if (req_hit) begin
                        ram_raddr = RAW'(req_port.data.row);
                        col_in    = CCW'(req_port.data.col);
                        state_in  = ST_CELL_RD;
                     end else begin
                        state_in  = ST_RESP;
                     end
                  end
                  lage_pkg::OP_STEP: begin
                     live_in     = '0;
                     res_cell_in = 1'b0;
                     row_in      = '0;
                     up_in       = '0;
                     mid_in      = '0;
                     dn_in       = '0;
                     if (used_rows == '0) begin
                        state_in = ST_ZERO;
                     end else begin
                        // fetch row 0, then row 1 to prime the window
                        ram_raddr = '0;
                        rd_use_in = 1'b1;
                        pre_in    = 1'b1;
                        state_in  = ST_LOAD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_CELL_RD: begin
            if (is_write_ff) begin
               // merge the new cell into the fetched row and write it back
               ram_we                   = 1'b1;
               ram_wdata                = ram_rdata;
               ram_wdata[CAW'(col_ff)]  = cell_val_ff;
               state_in                 = ST_IDLE;
            end else begin
               res_cell_in = ram_rdata[CAW'(col_ff)];
               state_in    = ST_RESP;
            end
         end

         ST_LOAD: begin
            // shift the window up by one row
            up_in  = mid_ff;
            mid_in = dn_ff;
            dn_in  = rd_use_ff ? (ram_rdata & col_mask) : '0;
            if (pre_ff) begin
               pre_in    = 1'b0;
               ram_raddr = RAW'(1);
               rd_use_in = (RCW'(1) < used_rows);
            end else begin
               col_in   = '0;
               new_in   = '0;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            // one cell per cycle across the used columns
            if (col_ff < used_cols) begin
               new_in[CAW'(col_ff)] = born;
               if (born && (live_ff != lage_pkg::LIVE_MAX)) begin
                  live_in = live_ff + LIVE_W'(1);
               end
               col_in = col_ff + CCW'(1);
            end else begin
               state_in = ST_WB;
            end
         end

         ST_WB: begin
            // the old row is already in the window, so overwrite it now
            ram_we    = 1'b1;
            ram_wdata = new_ff;
            ram_raddr = RAW'(row_p2);
            rd_use_in = (row_p2 < (RCW + 1)'(used_rows));
            row_in    = row_p1;
            if (row_p1 == used_rows) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_LOAD;
            end
         end

         ST_ZERO: begin
            // clear rows below the used area
            if (row_ff < RCW'(MAX_ROWS)) begin
               ram_we = 1'b1;
               row_in = row_p1;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.cell_out    = res_cell_ff;
               rsp_data_in.live_count  = live_ff;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rows_ff      <= lage_pkg::AREA_RESET;
         cols_ff      <= lage_pkg::AREA_RESET;
         rsp_valid_ff <= 1'b0;
         pre_ff       <= 1'b0;
         rd_use_ff    <= 1'b0;
         is_write_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
         pre_ff       <= pre_in;
         rd_use_ff    <= rd_use_in;
         is_write_ff  <= is_write_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      up_ff       <= up_in;
      mid_ff      <= mid_in;
      dn_ff       <= dn_in;
      new_ff      <= new_in;
      live_ff     <= live_in;
      res_cell_ff <= res_cell_in;
      cell_val_ff <= cell_val_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### src/lage_checker.sv
module lage_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input lage_pkg::req_data_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lage_pkg::rsp_data_type rsp_data
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result word changed while stalled");

   // the clearing pass follows reset, so no request is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken before the clearing pass");

   // a cell write gives no result word
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.opcode == lage_pkg::OP_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("cell write produced a result word");

   // a live cell comes only from a read, which reports no population
   a_read_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cell_out |-> (rsp_data.live_count == '0))
      else $error("read result carries a population");

endmodule

bind life_automaton_grid_engine lage_checker u_lage_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .req_data  (req_port.data),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_data  (rsp_port.data)
);
